[src/ffhp_pkg.sv]
`default_nettype none
package ffhp_pkg;

	// Field widths of the request and result channels.
	localparam int OPCODE_W       = 1;
	localparam int HOST_IDX_W     = 6;
	localparam int AMOUNT_W       = 16;
	localparam int USED_W         = 20;
	localparam int COMMIT_W       = 12;
	localparam int CLASS_W        = 8;
	localparam int HOSTS_IN_USE_W = 7;
	localparam int PLACED_HOST_W  = 7;
	localparam int PLACED_TOTAL_W = 32;
	localparam int PROD_W         = AMOUNT_W + COMMIT_W;

	// Configuration port.
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 12;

	localparam logic [CFG_INDEX_W-1:0] CFG_HOSTS_IN_USE       = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CRITICAL_CLASS     = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_COMMIT_CRITICAL    = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_COMMIT_NONCRITICAL = 4'd3;

	// Register reset values.
	localparam logic [HOSTS_IN_USE_W-1:0] RST_HOSTS_IN_USE       = 7'd64;
	localparam logic [CLASS_W-1:0]        RST_CRITICAL_CLASS     = 8'd1;
	localparam logic [COMMIT_W-1:0]       RST_COMMIT_CRITICAL    = 12'd256;
	localparam logic [COMMIT_W-1:0]       RST_COMMIT_NONCRITICAL = 12'd384;

	// Commitment of exactly 1.0 in Q4.8.
	localparam logic [COMMIT_W-1:0] COMMIT_ONE  = 12'd256;
	localparam logic [COMMIT_W-1:0] COMMIT_ZERO = 12'd0;

	localparam int DEF_MAX_HOSTS = 64;

	// Opcodes.
	localparam logic [OPCODE_W-1:0] OP_LOAD  = 1'b0;
	localparam logic [OPCODE_W-1:0] OP_PLACE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} ffhp_state_t;

	// One row of the host table.
	typedef struct packed {
		logic [AMOUNT_W-1:0] cap_cpu;
		logic [AMOUNT_W-1:0] cap_memory;
		logic [AMOUNT_W-1:0] cap_storage;
		logic [USED_W-1:0]   used_cpu;
		logic [USED_W-1:0]   used_memory;
		logic [USED_W-1:0]   used_storage;
		logic [COMMIT_W-1:0] commit_level;
	} host_entry_t;

	// Verdict of the fit stage on one host.
	typedef struct packed {
		logic        hit;
		logic        last;
		host_entry_t wb_entry;
	} eval_res_t;

endpackage
`default_nettype wire

[src/ffhp_ifs.sv]
`default_nettype none
interface ffhp_req_if;
	import ffhp_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [OPCODE_W-1:0]       opcode;
	logic [HOST_IDX_W-1:0]     host_index;
	logic [AMOUNT_W-1:0]       cpu_amount;
	logic [AMOUNT_W-1:0]       memory_amount;
	logic [AMOUNT_W-1:0]       storage_amount;
	logic [AMOUNT_W-1:0]       start_cpu_used;
	logic [AMOUNT_W-1:0]       start_memory_used;
	logic [AMOUNT_W-1:0]       start_storage_used;
	logic [COMMIT_W-1:0]       start_commit;
	logic [CLASS_W-1:0]        service_class;

	modport source (
		output valid, opcode, host_index, cpu_amount, memory_amount, storage_amount,
		output start_cpu_used, start_memory_used, start_storage_used, start_commit,
		output service_class,
		input  ready
	);
	modport sink (
		input  valid, opcode, host_index, cpu_amount, memory_amount, storage_amount,
		input  start_cpu_used, start_memory_used, start_storage_used, start_commit,
		input  service_class,
		output ready
	);
endinterface

interface ffhp_rsp_if;
	import ffhp_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [PLACED_HOST_W-1:0]  placed_host;
	logic [PLACED_TOTAL_W-1:0] placed_total;

	modport source (output valid, placed_host, placed_total, input ready);
	modport sink (input valid, placed_host, placed_total, output ready);
endinterface

interface ffhp_cfg_if;
	import ffhp_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[src/ffhp_host_mem.sv]
`default_nettype none
module ffhp_host_mem
	import ffhp_pkg::*;
#(
	parameter int MAX_HOSTS = DEF_MAX_HOSTS,
	parameter int AW        = 6
) (
	input  wire logic        clk,
	input  wire logic        we,
	input  wire logic [AW-1:0] waddr,
	input  wire host_entry_t wdata,
	input  wire logic        re,
	input  wire logic [AW-1:0] raddr,
	output host_entry_t      rdata_s1
);

	host_entry_t mem_q [MAX_HOSTS];

	// Single write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_s1 <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[src/ffhp_fit_eval.sv]
`default_nettype none
module ffhp_fit_eval
	import ffhp_pkg::*;
#(
	parameter int AW = 6
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                flush,
	input  wire logic                in_valid,
	input  wire logic [AW-1:0]       in_idx,
	input  wire logic                in_last,
	input  wire host_entry_t         rd_entry,
	input  wire logic [AMOUNT_W-1:0] req_cpu,
	input  wire logic [AMOUNT_W-1:0] req_memory,
	input  wire logic [AMOUNT_W-1:0] req_storage,
	input  wire logic                critical,
	input  wire logic [COMMIT_W-1:0] commit_critical,
	input  wire logic [COMMIT_W-1:0] commit_noncritical,
	output logic                     out_valid,
	output logic [AW-1:0]            out_idx,
	output eval_res_t                res
);

	logic              vld_s2;
	logic [AW-1:0]     idx_s2;
	logic              last_s2;
	host_entry_t       entry_s2;
	logic [PROD_W-1:0] prod_cpu_s2;
	logic [PROD_W-1:0] prod_mem_s2;

	logic [USED_W:0]   new_cpu;
	logic [USED_W:0]   new_mem;
	logic [USED_W:0]   new_sto;
	logic              overloaded;
	logic              scaled;
	logic              fit_cpu;
	logic              fit_mem;
	logic              fit_sto;
	logic [COMMIT_W-1:0] new_commit;

	// Stage 2 valid, cleared when the scan ends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= in_valid && !flush;
		end
	end

	// Scaled capacities: capacity times commitment, kept with eight fraction bits.
	always_ff @(posedge clk) begin
		idx_s2      <= in_idx;
		last_s2     <= in_last;
		entry_s2    <= rd_entry;
		prod_cpu_s2 <= PROD_W'(rd_entry.cap_cpu) * PROD_W'(rd_entry.commit_level);
		prod_mem_s2 <= PROD_W'(rd_entry.cap_memory) * PROD_W'(rd_entry.commit_level);
	end

	// Overload and fit tests on the host held in stage 2.
	always_comb begin
		new_cpu = (USED_W+1)'(entry_s2.used_cpu) + (USED_W+1)'(req_cpu);
		new_mem = (USED_W+1)'(entry_s2.used_memory) + (USED_W+1)'(req_memory);
		new_sto = (USED_W+1)'(entry_s2.used_storage) + (USED_W+1)'(req_storage);

		overloaded = ({entry_s2.used_cpu, 8'd0} > prod_cpu_s2)
			|| ({entry_s2.used_memory, 8'd0} > prod_mem_s2)
			|| (entry_s2.used_storage > USED_W'(entry_s2.cap_storage));

		scaled = !critical && (entry_s2.commit_level > COMMIT_ONE);
		if (scaled) begin
			fit_cpu = {new_cpu, 8'd0} <= (PROD_W+1)'(prod_cpu_s2);
			fit_mem = {new_mem, 8'd0} <= (PROD_W+1)'(prod_mem_s2);
		end else begin
			fit_cpu = new_cpu <= (USED_W+1)'(entry_s2.cap_cpu);
			fit_mem = new_mem <= (USED_W+1)'(entry_s2.cap_memory);
		end
		fit_sto = new_sto <= (USED_W+1)'(entry_s2.cap_storage);

		if (critical) begin
			new_commit = commit_critical;
		end else if (entry_s2.commit_level == COMMIT_ZERO) begin
			new_commit = commit_noncritical;
		end else begin
			new_commit = entry_s2.commit_level;
		end

		res.hit                   = vld_s2 && !overloaded && fit_cpu && fit_mem && fit_sto;
		res.last                  = last_s2;
		res.wb_entry              = entry_s2;
		res.wb_entry.used_cpu     = new_cpu[USED_W-1:0];
		res.wb_entry.used_memory  = new_mem[USED_W-1:0];
		res.wb_entry.used_storage = new_sto[USED_W-1:0];
		res.wb_entry.commit_level = new_commit;
	end

	assign out_valid = vld_s2;
	assign out_idx   = idx_s2;

endmodule
`default_nettype wire

[src/first_fit_host_placer_core.sv]
// First-fit host placer. A load request (opcode 0) writes one host row. A place
// request (opcode 1) reads the host table one row per cycle from host 0 and stops at
// the first host that is not overloaded and has room; that row is written back with
// the new usage and commitment. The scan covers n hosts, where n is the smaller of
// hosts_in_use and MAX_HOSTS; when n is zero nothing is read. The single read port of
// the host table feeds a two-stage pipeline: the registered read, then the registered
// multiply with the fit compare behind it. A finished result waits in an output
// register while the next request is taken; a later result is held back until that
// register has been emptied. The host table is not cleared by reset: every host that a
// place request can reach must be loaded first.
`default_nettype none
module first_fit_host_placer_core
	import ffhp_pkg::*;
#(
	parameter int MAX_HOSTS = DEF_MAX_HOSTS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ffhp_req_if.sink   req,
	ffhp_rsp_if.source rsp,
	ffhp_cfg_if.sink   cfg
);

	localparam int AW = (MAX_HOSTS > 1) ? $clog2(MAX_HOSTS) : 1;
	localparam int CW = AW + 1;

	ffhp_state_t state_q, state_d;

	logic [HOSTS_IN_USE_W-1:0] hosts_in_use_q;
	logic [CLASS_W-1:0]        critical_class_q;
	logic [COMMIT_W-1:0]       commit_critical_q;
	logic [COMMIT_W-1:0]       commit_noncritical_q;

	logic [CW-1:0]             scan_len;
	logic [CW-1:0]             scan_len_q;
	logic [CW-1:0]             issue_cnt_q;
	logic [AMOUNT_W-1:0]       req_cpu_q;
	logic [AMOUNT_W-1:0]       req_mem_q;
	logic [AMOUNT_W-1:0]       req_sto_q;
	logic                      critical_q;

	logic                      vld_s1;
	logic [AW-1:0]             idx_s1;
	logic                      last_s1;

	logic                      place_acc;
	logic                      load_we;
	logic                      rd_en;
	logic                      wb_en;
	logic                      scan_done;
	logic                      flush;
	logic                      out_free;

	host_entry_t               rd_entry_s1;
	host_entry_t               load_entry;
	host_entry_t               mem_wdata;
	logic [AW-1:0]             mem_waddr;
	logic                      evl_valid;
	logic [AW-1:0]             evl_idx;
	eval_res_t                 evl_res;

	logic [PLACED_HOST_W-1:0]  chosen_q;
	logic [PLACED_TOTAL_W-1:0] placed_count_q;
	logic                      out_valid_q;
	logic [PLACED_HOST_W-1:0]  out_host_q;
	logic [PLACED_TOTAL_W-1:0] out_total_q;

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hosts_in_use_q       <= RST_HOSTS_IN_USE;
			critical_class_q     <= RST_CRITICAL_CLASS;
			commit_critical_q    <= RST_COMMIT_CRITICAL;
			commit_noncritical_q <= RST_COMMIT_NONCRITICAL;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_HOSTS_IN_USE:       hosts_in_use_q       <= cfg.data[HOSTS_IN_USE_W-1:0];
				CFG_CRITICAL_CLASS:     critical_class_q     <= cfg.data[CLASS_W-1:0];
				CFG_COMMIT_CRITICAL:    commit_critical_q    <= cfg.data[COMMIT_W-1:0];
				CFG_COMMIT_NONCRITICAL: commit_noncritical_q <= cfg.data[COMMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Number of hosts a place request scans.
	assign scan_len = (32'(hosts_in_use_q) > 32'(MAX_HOSTS)) ? CW'(MAX_HOSTS)
		: CW'(hosts_in_use_q);

	// Control: next state and handshake.
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		rd_en     = 1'b0;
		scan_done = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid && (req.opcode == OP_PLACE)) begin
					state_d = (scan_len == '0) ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_en = issue_cnt_q < scan_len_q;
				if (evl_valid && (evl_res.hit || evl_res.last)) begin
					scan_done = 1'b1;
					state_d   = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign place_acc = req.valid && req.ready && (req.opcode == OP_PLACE);
	assign load_we   = req.valid && req.ready && (req.opcode == OP_LOAD)
		&& (32'(req.host_index) < 32'(MAX_HOSTS));
	assign wb_en     = (state_q == ST_SCAN) && evl_valid && evl_res.hit;
	assign flush     = (state_q != ST_SCAN) || scan_done;
	assign out_free  = !out_valid_q || rsp.ready;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			issue_cnt_q    <= '0;
			vld_s1         <= 1'b0;
			placed_count_q <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (place_acc) begin
				issue_cnt_q <= '0;
			end else if (rd_en) begin
				issue_cnt_q <= issue_cnt_q + 1'b1;
			end
			vld_s1 <= rd_en && !flush;
			if (wb_en) begin
				placed_count_q <= placed_count_q + 1'b1;
			end
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request, pipeline and result payload.
	always_ff @(posedge clk) begin
		if (place_acc) begin
			scan_len_q <= scan_len;
			req_cpu_q  <= req.cpu_amount;
			req_mem_q  <= req.memory_amount;
			req_sto_q  <= req.storage_amount;
			critical_q <= req.service_class == critical_class_q;
			chosen_q   <= '0;
		end else if (wb_en) begin
			chosen_q <= PLACED_HOST_W'(CW'(evl_idx) + 1'b1);
		end
		idx_s1  <= issue_cnt_q[AW-1:0];
		last_s1 <= (issue_cnt_q + 1'b1) == scan_len_q;
		if ((state_q == ST_DONE) && out_free) begin
			out_host_q  <= chosen_q;
			out_total_q <= placed_count_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.placed_host  = out_host_q;
	assign rsp.placed_total = out_total_q;

	// Host table write: loads while idle, write-back of the chosen host while scanning.
	always_comb begin
		load_entry.cap_cpu      = req.cpu_amount;
		load_entry.cap_memory   = req.memory_amount;
		load_entry.cap_storage  = req.storage_amount;
		load_entry.used_cpu     = USED_W'(req.start_cpu_used);
		load_entry.used_memory  = USED_W'(req.start_memory_used);
		load_entry.used_storage = USED_W'(req.start_storage_used);
		load_entry.commit_level = req.start_commit;
		mem_wdata = wb_en ? evl_res.wb_entry : load_entry;
		mem_waddr = wb_en ? evl_idx : AW'(req.host_index);
	end

	ffhp_host_mem #(
		.MAX_HOSTS (MAX_HOSTS),
		.AW        (AW)
	) u_mem (
		.clk      (clk),
		.we       (load_we || wb_en),
		.waddr    (mem_waddr),
		.wdata    (mem_wdata),
		.re       (rd_en),
		.raddr    (issue_cnt_q[AW-1:0]),
		.rdata_s1 (rd_entry_s1)
	);

	ffhp_fit_eval #(
		.AW (AW)
	) u_eval (
		.clk                (clk),
		.arst_n             (arst_n),
		.flush              (flush),
		.in_valid           (vld_s1),
		.in_idx             (idx_s1),
		.in_last            (last_s1),
		.rd_entry           (rd_entry_s1),
		.req_cpu            (req_cpu_q),
		.req_memory         (req_mem_q),
		.req_storage        (req_sto_q),
		.critical           (critical_q),
		.commit_critical    (commit_critical_q),
		.commit_noncritical (commit_noncritical_q),
		.out_valid          (evl_valid),
		.out_idx            (evl_idx),
		.res                (evl_res)
	);

	// A write-back never collides with a load.
	a_wb_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		wb_en |-> !load_we)
		else $error("write-back and load in the same cycle");

	// The placed count moves only with a write-back.
	a_count_only_on_wb: assert property (@(posedge clk) disable iff (!arst_n)
		!wb_en |=> $stable(placed_count_q))
		else $error("placed count changed without a placement");

	// Reads never run past the scan length.
	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (issue_cnt_q < scan_len_q) && (scan_len_q <= CW'(MAX_HOSTS)))
		else $error("host read beyond scan length");

	// The pipeline is empty outside a scan.
	a_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_SCAN) |-> !vld_s1 && !evl_valid)
		else $error("scan pipeline busy outside a scan");

endmodule
`default_nettype wire

[dv/ffhp_tb_pkg.sv]
`timescale 1ns / 100ps
package ffhp_tb_pkg;
	import ffhp_pkg::*;

	// One request as it crosses the request channel.
	typedef struct packed {
		logic [OPCODE_W-1:0]   opcode;
		logic [HOST_IDX_W-1:0] host_index;
		logic [AMOUNT_W-1:0]   cpu_amount;
		logic [AMOUNT_W-1:0]   memory_amount;
		logic [AMOUNT_W-1:0]   storage_amount;
		logic [AMOUNT_W-1:0]   start_cpu_used;
		logic [AMOUNT_W-1:0]   start_memory_used;
		logic [AMOUNT_W-1:0]   start_storage_used;
		logic [COMMIT_W-1:0]   start_commit;
		logic [CLASS_W-1:0]    service_class;
	} placer_request_t;

	// One placement answer.
	typedef struct packed {
		logic [PLACED_HOST_W-1:0]  placed_host;
		logic [PLACED_TOTAL_W-1:0] placed_total;
	} placement_t;

	// Shadow host table and registers; predicts every placement and checks the answers.
	class placement_checker;
		logic [AMOUNT_W-1:0]       cap_cpu[DEF_MAX_HOSTS];
		logic [AMOUNT_W-1:0]       cap_memory[DEF_MAX_HOSTS];
		logic [AMOUNT_W-1:0]       cap_storage[DEF_MAX_HOSTS];
		logic [USED_W-1:0]         used_cpu[DEF_MAX_HOSTS];
		logic [USED_W-1:0]         used_memory[DEF_MAX_HOSTS];
		logic [USED_W-1:0]         used_storage[DEF_MAX_HOSTS];
		logic [COMMIT_W-1:0]       commit_lvl[DEF_MAX_HOSTS];
		bit                        loaded[DEF_MAX_HOSTS];
		logic [PLACED_TOTAL_W-1:0] placed_count;

		logic [HOSTS_IN_USE_W-1:0] hosts_in_use;
		logic [CLASS_W-1:0]        critical_class;
		logic [COMMIT_W-1:0]       commit_critical;
		logic [COMMIT_W-1:0]       commit_noncritical;

		placement_t expected_placements[$];
		int unsigned mismatches;
		int unsigned results_seen;
		int unsigned loads_seen;
		int unsigned places_seen;
		int unsigned placed_seen;
		int unsigned critical_seen;

		function new();
			placed_count       = '0;
			hosts_in_use       = RST_HOSTS_IN_USE;
			critical_class     = RST_CRITICAL_CLASS;
			commit_critical    = RST_COMMIT_CRITICAL;
			commit_noncritical = RST_COMMIT_NONCRITICAL;
			foreach (loaded[h]) loaded[h] = 1'b0;
			mismatches    = 0;
			results_seen  = 0;
			loads_seen    = 0;
			places_seen   = 0;
			placed_seen   = 0;
			critical_seen = 0;
		endfunction

		// Registers mirror the block; unknown indexes are dropped.
		function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_HOSTS_IN_USE:       hosts_in_use = data[HOSTS_IN_USE_W-1:0];
				CFG_CRITICAL_CLASS:     critical_class = data[CLASS_W-1:0];
				CFG_COMMIT_CRITICAL:    commit_critical = data[COMMIT_W-1:0];
				CFG_COMMIT_NONCRITICAL: commit_noncritical = data[COMMIT_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned scan_length();
			return (hosts_in_use > DEF_MAX_HOSTS) ? DEF_MAX_HOSTS : int'(hosts_in_use);
		endfunction

		// True when a place request now would read a host row that was never loaded.
		function bit scan_reaches_unloaded();
			for (int h = 0; h < scan_length(); h++) begin
				if (!loaded[h]) return 1'b1;
			end
			return 1'b0;
		endfunction

		// Usage against capacity times a Q4.8 commitment, exactly.
		function bit within_scaled(longint unsigned amount, longint unsigned cap,
				longint unsigned commit);
			return (amount << 8) <= cap * commit;
		endfunction

		function bit host_overloaded(int h);
			return !within_scaled(64'(used_cpu[h]), 64'(cap_cpu[h]), 64'(commit_lvl[h]))
				|| !within_scaled(64'(used_memory[h]), 64'(cap_memory[h]), 64'(commit_lvl[h]))
				|| used_storage[h] > 20'(cap_storage[h]);
		endfunction

		// First-fit scan over the shadow table; updates the chosen row.
		function placement_t predict_placement(placer_request_t r);
			placement_t      res;
			bit              crit;
			bit              fits;
			longint unsigned nc;
			longint unsigned nm;
			longint unsigned ns;
			res.placed_host = '0;
			crit = (r.service_class == critical_class);
			for (int h = 0; h < scan_length(); h++) begin
				if (host_overloaded(h)) continue;
				nc = 64'(used_cpu[h]) + 64'(r.cpu_amount);
				nm = 64'(used_memory[h]) + 64'(r.memory_amount);
				ns = 64'(used_storage[h]) + 64'(r.storage_amount);
				if (!crit && commit_lvl[h] > COMMIT_ONE) begin
					fits = within_scaled(nc, 64'(cap_cpu[h]), 64'(commit_lvl[h]))
						&& within_scaled(nm, 64'(cap_memory[h]), 64'(commit_lvl[h]));
				end else begin
					fits = nc <= 64'(cap_cpu[h]) && nm <= 64'(cap_memory[h]);
				end
				fits = fits && ns <= 64'(cap_storage[h]);
				if (!fits) continue;
				used_cpu[h]     = USED_W'(nc);
				used_memory[h]  = USED_W'(nm);
				used_storage[h] = USED_W'(ns);
				placed_count    = placed_count + 1'b1;
				if (crit) begin
					commit_lvl[h] = commit_critical;
				end else if (commit_lvl[h] == COMMIT_ZERO) begin
					commit_lvl[h] = commit_noncritical;
				end
				res.placed_host = PLACED_HOST_W'(h + 1);
				break;
			end
			res.placed_total = placed_count;
			return res;
		endfunction

		// An accepted request: loads update the table, places queue an expected answer.
		function void note_request(placer_request_t r);
			placement_t res;
			if (r.opcode == OP_LOAD) begin
				cap_cpu[r.host_index]      = r.cpu_amount;
				cap_memory[r.host_index]   = r.memory_amount;
				cap_storage[r.host_index]  = r.storage_amount;
				used_cpu[r.host_index]     = USED_W'(r.start_cpu_used);
				used_memory[r.host_index]  = USED_W'(r.start_memory_used);
				used_storage[r.host_index] = USED_W'(r.start_storage_used);
				commit_lvl[r.host_index]   = r.start_commit;
				loaded[r.host_index]       = 1'b1;
				loads_seen++;
			end else begin
				if (r.service_class == critical_class) critical_seen++;
				res = predict_placement(r);
				if (res.placed_host != '0) placed_seen++;
				places_seen++;
				expected_placements.push_back(res);
			end
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, msg);
		endfunction

		// An answer from the block against the oldest expectation.
		function void check_placement(placement_t got);
			placement_t want;
			results_seen++;
			if (expected_placements.size() == 0) begin
				report($sformatf("answer %0d arrived with none expected (host %0d, total %0d)",
					results_seen, got.placed_host, got.placed_total));
				return;
			end
			want = expected_placements.pop_front();
			if (got.placed_host !== want.placed_host)
				report($sformatf("answer %0d placed_host: expected %0d, got %0d",
					results_seen, want.placed_host, got.placed_host));
			if (got.placed_total !== want.placed_total)
				report($sformatf("answer %0d placed_total: expected %0d, got %0d",
					results_seen, want.placed_total, got.placed_total));
		endfunction

		function int unsigned pending();
			return expected_placements.size();
		endfunction
	endclass

endpackage

[dv/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;
	import ffhp_pkg::*;
	import ffhp_tb_pkg::*;

	localparam int NUM_PHASES      = 8;
	localparam int ITEMS_PER_PHASE = 80;
	localparam int SETTLE_CYCLES   = DEF_MAX_HOSTS + 16;
	localparam int CYCLE_LIMIT     = 1000000;

	// A register index that the block does not decode.
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 4'd15;

	// Settings for each random phase.
	localparam int PH_HOSTS[NUM_PHASES]    = '{64, 127, 17, 64, 1, 100, 64, 33};
	localparam int PH_CLASS[NUM_PHASES]    = '{0, 255, 1, 128, 37, 200, 255, 0};
	localparam int PH_CRIT[NUM_PHASES]     = '{4095, 0, 256, 512, 1000, 300, 128, 4095};
	localparam int PH_NONCRIT[NUM_PHASES]  = '{384, 4095, 0, 257, 640, 256, 1, 4095};
	localparam int PH_SPAN[NUM_PHASES]     = '{4000, 65535, 1000, 20000, 4000, 2000, 65535, 8000};
	localparam int SEND_IDLE[4]            = '{0, 77, 0, 20};
	localparam int RECV_STALL[4]           = '{0, 0, 77, 20};

	logic clk;
	logic arst_n;

	ffhp_req_if req_ch();
	ffhp_rsp_if rsp_ch();
	ffhp_cfg_if cfg_ch();

	first_fit_host_placer_core #(
		.MAX_HOSTS(DEF_MAX_HOSTS)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch),
		.cfg   (cfg_ch)
	);

	placement_checker sb;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned cycle_count = 0;
	int unsigned settings_used = 0;
	logic [CLASS_W-1:0] cur_class = RST_CRITICAL_CLASS;

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The result side stalls at random according to the current mode.
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Every answer taken from the block is checked.
	always @(posedge clk) begin
		placement_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.placed_host  = rsp_ch.placed_host;
			got.placed_total = rsp_ch.placed_total;
			sb.check_placement(got);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d answers outstanding.",
				cycle_count, sb.pending());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Sends one request, after random idle cycles; entered and left at a falling edge.
	task automatic send_request(placer_request_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.opcode             <= r.opcode;
		req_ch.host_index         <= r.host_index;
		req_ch.cpu_amount         <= r.cpu_amount;
		req_ch.memory_amount      <= r.memory_amount;
		req_ch.storage_amount     <= r.storage_amount;
		req_ch.start_cpu_used     <= r.start_cpu_used;
		req_ch.start_memory_used  <= r.start_memory_used;
		req_ch.start_storage_used <= r.start_storage_used;
		req_ch.start_commit       <= r.start_commit;
		req_ch.service_class      <= r.service_class;
		req_ch.valid              <= 1'b1;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		sb.note_request(r);
		@(negedge clk);
	endtask

	// Holds the request channel quiet until every expected answer has come back.
	task automatic wait_for_results();
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
	endtask

	// Idle point for register writes: nothing outstanding and the last scan finished.
	task automatic quiesce();
		wait_for_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One register write; valid stays high for a following write.
	task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		cfg_ch.valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		sb.set_register(idx, data);
		@(negedge clk);
	endtask

	// Writes all four registers, plus a write to an undecoded index.
	task automatic write_settings(int hosts, int cls, int crit, int noncrit);
		cfg_write(CFG_SPARE, CFG_DATA_W'($urandom));
		cfg_write(CFG_HOSTS_IN_USE, CFG_DATA_W'(hosts));
		cfg_write(CFG_CRITICAL_CLASS, CFG_DATA_W'(cls));
		cfg_write(CFG_COMMIT_CRITICAL, CFG_DATA_W'(crit));
		cfg_write(CFG_COMMIT_NONCRITICAL, CFG_DATA_W'(noncrit));
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
		cur_class = CLASS_W'(cls);
		settings_used++;
	endtask

	task automatic set_idling(int mode);
		send_idle_pct  = SEND_IDLE[mode];
		recv_stall_pct = RECV_STALL[mode];
	endtask

	task automatic load_host(int idx, int cc, int cm, int cs, int uc, int um, int us,
			int commit);
		placer_request_t r;
		r = '0;
		r.opcode             = OP_LOAD;
		r.host_index         = HOST_IDX_W'(idx);
		r.cpu_amount         = AMOUNT_W'(cc);
		r.memory_amount      = AMOUNT_W'(cm);
		r.storage_amount     = AMOUNT_W'(cs);
		r.start_cpu_used     = AMOUNT_W'(uc);
		r.start_memory_used  = AMOUNT_W'(um);
		r.start_storage_used = AMOUNT_W'(us);
		r.start_commit       = COMMIT_W'(commit);
		send_request(r);
	endtask

	task automatic place_request(int cls, int c, int m, int s);
		placer_request_t r;
		r = '0;
		r.opcode         = OP_PLACE;
		r.cpu_amount     = AMOUNT_W'(c);
		r.memory_amount  = AMOUNT_W'(m);
		r.storage_amount = AMOUNT_W'(s);
		r.service_class  = CLASS_W'(cls);
		send_request(r);
	endtask

	// Capacities: mostly within the phase span, sometimes empty or full scale.
	function automatic logic [AMOUNT_W-1:0] pick_capacity(int unsigned span);
		case ($urandom_range(9))
			0: return '1;
			1: return '0;
			default: return AMOUNT_W'($urandom_range(span));
		endcase
	endfunction

	// Starting usage: idle, within capacity, or anything (often overloaded).
	function automatic logic [AMOUNT_W-1:0] pick_usage(logic [AMOUNT_W-1:0] cap);
		case ($urandom_range(4))
			0, 1: return '0;
			2, 3: return AMOUNT_W'($urandom_range(cap));
			default: return AMOUNT_W'($urandom);
		endcase
	endfunction

	// Commitment: the values around 1.0 and 0 matter most.
	function automatic logic [COMMIT_W-1:0] pick_commit();
		case ($urandom_range(7))
			0: return COMMIT_ZERO;
			1: return COMMIT_ONE - 1'b1;
			2: return COMMIT_ONE;
			3: return COMMIT_ONE + 1'b1;
			4: return 12'd384;
			5: return 12'd512;
			6: return '1;
			default: return COMMIT_W'($urandom);
		endcase
	endfunction

	// Requested amounts: mostly small, so that hosts fill up over many requests.
	function automatic logic [AMOUNT_W-1:0] pick_amount(int unsigned span);
		case ($urandom_range(19))
			0: return '1;
			1: return '0;
			2, 3, 4, 5: return AMOUNT_W'($urandom_range(span));
			default: return AMOUNT_W'($urandom_range(span / 8));
		endcase
	endfunction

	function automatic placer_request_t random_host_load(int idx, int unsigned span);
		placer_request_t r;
		r.opcode             = OP_LOAD;
		r.host_index         = HOST_IDX_W'(idx);
		r.cpu_amount         = pick_capacity(span);
		r.memory_amount      = pick_capacity(span);
		r.storage_amount     = pick_capacity(span);
		r.start_cpu_used     = pick_usage(r.cpu_amount);
		r.start_memory_used  = pick_usage(r.memory_amount);
		r.start_storage_used = pick_usage(r.storage_amount);
		r.start_commit       = pick_commit();
		r.service_class      = CLASS_W'($urandom);
		return r;
	endfunction

	// Main sequence.
	initial begin
		placer_request_t r;
		int unsigned     span;
		sb = new();
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.opcode    = OP_LOAD;
		req_ch.host_index         = '0;
		req_ch.cpu_amount         = '0;
		req_ch.memory_amount      = '0;
		req_ch.storage_amount     = '0;
		req_ch.start_cpu_used     = '0;
		req_ch.start_memory_used  = '0;
		req_ch.start_storage_used = '0;
		req_ch.start_commit       = '0;
		req_ch.service_class      = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_HOSTS_IN_USE;
		cfg_ch.data  = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part on a four-host table: overload on each resource, scaled and
		// raw fits, commitment exactly 1.0 and below, fresh hosts and critical requests.
		set_idling(0);
		write_settings(4, 200, 4095, 0);
		load_host(0, 100, 100, 100, 201, 0, 0, 512);
		load_host(1, 1000, 1000, 1000, 0, 1001, 0, 256);
		load_host(2, 65535, 65535, 100, 0, 0, 101, 4095);
		load_host(3, 65535, 65535, 65535, 65535, 65535, 0, 4095);
		place_request(200, 1, 0, 0);
		place_request(3, 65535, 65535, 65535);
		load_host(0, 10, 10, 10, 0, 0, 0, 0);
		place_request(0, 10, 10, 10);
		place_request(0, 0, 0, 0);
		load_host(1, 100, 100, 100, 50, 50, 50, 256);
		place_request(0, 50, 50, 50);
		load_host(2, 100, 100, 100, 0, 0, 0, 512);
		place_request(0, 150, 150, 0);
		place_request(200, 1, 1, 1);
		load_host(3, 65535, 65535, 65535, 0, 0, 0, 100);
		place_request(200, 65535, 65535, 65535);
		place_request(255, 0, 0, 0);
		quiesce();
		// An empty scan leaves every request unplaced.
		write_settings(0, 255, COMMIT_ONE, 4095);
		place_request(255, 1, 1, 1);
		place_request(3, 0, 0, 0);

		// Random phases, each with its own settings and idling mode.
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			quiesce();
			span = PH_SPAN[phase];
			write_settings(PH_HOSTS[phase], PH_CLASS[phase], PH_CRIT[phase],
				PH_NONCRIT[phase]);
			set_idling(phase % 4);
			if (phase == 0) begin
				for (int h = 0; h < DEF_MAX_HOSTS; h++) send_request(random_host_load(h, span));
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Now and then the sender holds off until all answers are back.
				if (n == ITEMS_PER_PHASE / 2 || $urandom_range(49) == 0) wait_for_results();
				if ($urandom_range(99) < 25 || sb.scan_reaches_unloaded()) begin
					r = random_host_load(int'($urandom_range(DEF_MAX_HOSTS - 1)), span);
				end else begin
					r.opcode             = OP_PLACE;
					r.host_index         = HOST_IDX_W'($urandom);
					r.cpu_amount         = pick_amount(span);
					r.memory_amount      = pick_amount(span);
					r.storage_amount     = pick_amount(span);
					r.start_cpu_used     = AMOUNT_W'($urandom);
					r.start_memory_used  = AMOUNT_W'($urandom);
					r.start_storage_used = AMOUNT_W'($urandom);
					r.start_commit       = COMMIT_W'($urandom);
					r.service_class      = ($urandom_range(2) == 0) ? cur_class
						: CLASS_W'($urandom);
				end
				send_request(r);
			end
		end
		quiesce();

		$display("Covered %0d host loads and %0d place requests (%0d placed, %0d critical)",
			sb.loads_seen, sb.places_seen, sb.placed_seen, sb.critical_seen);
		$display("across %0d register settings; %0d answers checked, %0d mismatches.",
			settings_used, sb.results_seen, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
